// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the ALU block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property checked on each rising clock edge outside reset.
`define ASSERT_AT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen on a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/ealu_pkg.sv =====
// Types and constants of the 8-bit ALU with flags.
package ealu_pkg;

	// Operation codes
	typedef enum logic [4:0] {
		OP_ADD      = 5'd0,
		OP_ADC      = 5'd1,
		OP_SUB      = 5'd2,
		OP_SBC      = 5'd3,
		OP_AND      = 5'd4,
		OP_XOR      = 5'd5,
		OP_OR       = 5'd6,
		OP_CP       = 5'd7,
		OP_INC      = 5'd8,
		OP_DEC      = 5'd9,
		OP_RLC      = 5'd10,
		OP_RRC      = 5'd11,
		OP_RL       = 5'd12,
		OP_RR       = 5'd13,
		OP_SLA      = 5'd14,
		OP_SRA      = 5'd15,
		OP_SWAP     = 5'd16,
		OP_SRL      = 5'd17,
		OP_RLCA     = 5'd18,
		OP_RRCA     = 5'd19,
		OP_RLA      = 5'd20,
		OP_RRA      = 5'd21,
		OP_BIT      = 5'd22,
		OP_RES      = 5'd23,
		OP_SET      = 5'd24,
		OP_DAA      = 5'd25,
		OP_CPL      = 5'd26,
		OP_SCF      = 5'd27,
		OP_CCF      = 5'd28,
		OP_ADD16    = 5'd29,
		OP_ADDSPREL = 5'd30,
		OP_UNUSED   = 5'd31
	} alu_op_t;

	// Flag bit positions
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// Decimal adjust constants
	localparam logic [7:0] DAA_HIGH_ADJ   = 8'h60;
	localparam logic [7:0] DAA_LOW_ADJ    = 8'h06;
	localparam logic [7:0] DAA_HIGH_LIMIT = 8'h99;
	localparam logic [3:0] DAA_DIGIT_MAX  = 4'h9;

	// Stream widths
	localparam int S_DATA_W = 56;
	localparam int S_USER_W = 5;
	localparam int M_DATA_W = 32;

	// One operation with its operands
	typedef struct packed {
		alu_op_t     op;
		logic [7:0]  acc;
		logic [7:0]  operand;
		logic [15:0] wide_base;
		logic [15:0] wide_operand;
		logic [2:0]  bit_index;
		logic [3:0]  flags_in;
	} alu_in_t;

	// One result
	typedef struct packed {
		logic [7:0]  result;
		logic [15:0] wide_result;
		logic [3:0]  flags_out;
		logic        writes_result;
	} alu_out_t;

endpackage

// ===== src/eight_bit_alu_with_flags.sv =====
// Top level of the ALU: input register, combinational datapath, result register.
//
// Usage:
//   Operations enter on the s_axis channel: tuser carries the operation code,
//   tdata carries the accumulator, operand, 16-bit base and operand, bit index
//   and incoming flags. Results leave on the m_axis channel, one result item
//   per operation item, in order: 8-bit result, 16-bit result, new flags and
//   the write-back flag.
//   Path: an accepted item is registered in the input stage, runs through the
//   datapath and lands in the result register, from which it can be taken on
//   the output (two register stages).
//   Throughput: one item per clock cycle while m_axis_tready is high, set by
//   the combinational datapath between the registers; both stages move together.
//   Stalls: when m_axis_tready is low the result is held, the input stage
//   keeps one more item, and s_axis_tready drops only when both are full.
//   Reset: arst_n clears both valid flags at once; no item is in flight after
//   reset and the block is ready on the first cycle.
module eight_bit_alu_with_flags (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// acc, operand, wide_base, wide_operand, bit_index, flags_in, zero pad
	input  logic [ealu_pkg::S_DATA_W-1:0] s_axis_tdata,
	// op
	input  logic [ealu_pkg::S_USER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// result, wide_result, flags_out, writes_result, zero pad
	output logic [ealu_pkg::M_DATA_W-1:0] m_axis_tdata
);
	import ealu_pkg::*;

	`include "assert_macros.svh"

	alu_in_t  item_s1;
	logic     valid_s1;
	alu_out_t res_comb;
	alu_out_t res_s2;
	logic     valid_s2;
	logic     s_accept;
	logic     s2_ready;
	logic     s2_load;

	// Handshake between the stages
	assign s2_ready      = !valid_s2 || m_axis_tready;
	assign s2_load       = valid_s1 && s2_ready;
	assign s_axis_tready = !valid_s1 || s2_ready;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (s2_load) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.op           <= alu_op_t'(s_axis_tuser[4:0]);
			item_s1.acc          <= s_axis_tdata[7:0];
			item_s1.operand      <= s_axis_tdata[15:8];
			item_s1.wide_base    <= s_axis_tdata[31:16];
			item_s1.wide_operand <= s_axis_tdata[47:32];
			item_s1.bit_index    <= s_axis_tdata[50:48];
			item_s1.flags_in     <= s_axis_tdata[54:51];
		end
	end

	// Datapath
	ealu_core u_core (
		.item (item_s1),
		.res  (res_comb)
	);

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (s2_load) begin
			res_s2 <= res_comb;
		end
	end

	// Output packing
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2.writes_result, res_s2.flags_out,
		res_s2.wide_result, res_s2.result};

	// Checks
	`ASSERT_AT(a_load_fills_s1, clk, arst_n, s_accept |=> valid_s1,
		"accepted item did not reach the input stage")
	`ASSERT_AT(a_s1_held, clk, arst_n, (valid_s1 && !s2_load && !s_accept) |=> valid_s1,
		"item dropped from the input stage without moving on")
	`ASSERT_NEVER(a_cp_no_write, clk, arst_n,
		valid_s1 && (item_s1.op == OP_CP) && res_comb.writes_result,
		"compare produced a write-back")
	`ASSERT_NEVER(a_wide_zero, clk, arst_n,
		valid_s1 && (item_s1.op != OP_ADD16) && (item_s1.op != OP_ADDSPREL)
		&& (res_comb.wide_result != 16'h0000),
		"16-bit result nonzero for an 8-bit operation")

endmodule

// ===== src/ealu_core.sv =====
// Combinational datapath of the ALU: adders, shifter, bit unit, decimal adjust and flags.
module ealu_core (
	input  ealu_pkg::alu_in_t  item,
	output ealu_pkg::alu_out_t res
);
	import ealu_pkg::*;

	// Shift and rotate kinds, shared by the CB group and the accumulator group
	typedef enum logic [2:0] {
		SH_RLC  = 3'd0,
		SH_RRC  = 3'd1,
		SH_RL   = 3'd2,
		SH_RR   = 3'd3,
		SH_SLA  = 3'd4,
		SH_SRA  = 3'd5,
		SH_SWAP = 3'd6,
		SH_SRL  = 3'd7
	} shift_kind_t;

	logic        fz, fn, fh, fc;
	logic        cin;
	logic [8:0]  add_sum;
	logic [4:0]  add_half;
	logic [8:0]  sub_diff;
	logic [4:0]  sub_half;
	logic [7:0]  a, v;
	logic [7:0]  bit_mask;
	logic        acc_shift;
	logic [7:0]  sh_in;
	logic [4:0]  sh_code;
	shift_kind_t sh_kind;
	logic [7:0]  sh_out;
	logic        sh_c;
	logic        daa_hi, daa_lo;
	logic [7:0]  daa_adj;
	logic [7:0]  daa_val;
	logic [16:0] w16_sum;
	logic [12:0] w16_half;
	logic [15:0] sp_sum;
	logic [4:0]  sp_half;
	logic [8:0]  sp_low;

	assign a  = item.acc;
	assign v  = item.operand;
	assign fz = item.flags_in[FLAG_Z];
	assign fn = item.flags_in[FLAG_N];
	assign fh = item.flags_in[FLAG_H];
	assign fc = item.flags_in[FLAG_C];

	// Carry in only for the with-carry forms
	assign cin = ((item.op == OP_ADC) || (item.op == OP_SBC)) & fc;

	// 8-bit add and subtract with nibble carries
	assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, cin};
	assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
	assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, cin};
	assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

	// Single-bit mask for bit, res, set
	assign bit_mask = 8'h01 << item.bit_index;

	// Shifter: accumulator forms reuse the first four kinds
	assign acc_shift = (item.op >= OP_RLCA);
	assign sh_in     = acc_shift ? a : v;
	assign sh_code   = acc_shift ? (item.op - OP_RLCA) : (item.op - OP_RLC);
	assign sh_kind   = shift_kind_t'(sh_code[2:0]);

	always_comb begin
		case (sh_kind)
			SH_RLC: begin
				sh_out = {sh_in[6:0], sh_in[7]};
				sh_c   = sh_in[7];
			end
			SH_RRC: begin
				sh_out = {sh_in[0], sh_in[7:1]};
				sh_c   = sh_in[0];
			end
			SH_RL: begin
				sh_out = {sh_in[6:0], fc};
				sh_c   = sh_in[7];
			end
			SH_RR: begin
				sh_out = {fc, sh_in[7:1]};
				sh_c   = sh_in[0];
			end
			SH_SLA: begin
				sh_out = {sh_in[6:0], 1'b0};
				sh_c   = sh_in[7];
			end
			SH_SRA: begin
				sh_out = {sh_in[7], sh_in[7:1]};
				sh_c   = sh_in[0];
			end
			SH_SWAP: begin
				sh_out = {sh_in[3:0], sh_in[7:4]};
				sh_c   = 1'b0;
			end
			SH_SRL: begin
				sh_out = {1'b0, sh_in[7:1]};
				sh_c   = sh_in[0];
			end
			default: begin
				sh_out = sh_in;
				sh_c   = 1'b0;
			end
		endcase
	end

	// Decimal adjust: correction picked from N, H, C and the digits
	assign daa_hi  = fn ? fc : (fc || (a > DAA_HIGH_LIMIT));
	assign daa_lo  = fn ? fh : (fh || (a[3:0] > DAA_DIGIT_MAX));
	assign daa_adj = (daa_hi ? DAA_HIGH_ADJ : 8'h00) | (daa_lo ? DAA_LOW_ADJ : 8'h00);
	assign daa_val = fn ? (a - daa_adj) : (a + daa_adj);

	// 16-bit adds
	assign w16_sum  = {1'b0, item.wide_base} + {1'b0, item.wide_operand};
	assign w16_half = {1'b0, item.wide_base[11:0]} + {1'b0, item.wide_operand[11:0]};
	assign sp_sum   = item.wide_base + {{8{v[7]}}, v};
	assign sp_half  = {1'b0, item.wide_base[3:0]} + {1'b0, v[3:0]};
	assign sp_low   = {1'b0, item.wide_base[7:0]} + {1'b0, v};

	// Result and flag selection
	always_comb begin
		res.result        = 8'h00;
		res.wide_result   = 16'h0000;
		res.flags_out     = item.flags_in;
		res.writes_result = 1'b1;
		case (item.op)
			OP_ADD, OP_ADC: begin
				res.result    = add_sum[7:0];
				res.flags_out = {add_sum[7:0] == 8'h00, 1'b0, add_half[4], add_sum[8]};
			end
			OP_SUB, OP_SBC: begin
				res.result    = sub_diff[7:0];
				res.flags_out = {sub_diff[7:0] == 8'h00, 1'b1, sub_half[4], sub_diff[8]};
			end
			OP_CP: begin
				res.writes_result = 1'b0;
				res.flags_out     = {sub_diff[7:0] == 8'h00, 1'b1, sub_half[4], sub_diff[8]};
			end
			OP_AND: begin
				res.result    = a & v;
				res.flags_out = {(a & v) == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			OP_XOR: begin
				res.result    = a ^ v;
				res.flags_out = {(a ^ v) == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			OP_OR: begin
				res.result    = a | v;
				res.flags_out = {(a | v) == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			OP_INC: begin
				res.result    = v + 8'h01;
				res.flags_out = {v == 8'hff, 1'b0, v[3:0] == 4'hf, fc};
			end
			OP_DEC: begin
				res.result    = v - 8'h01;
				res.flags_out = {v == 8'h01, 1'b1, v[3:0] == 4'h0, fc};
			end
			OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
				res.result    = sh_out;
				res.flags_out = {sh_out == 8'h00, 1'b0, 1'b0, sh_c};
			end
			OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
				res.result    = sh_out;
				res.flags_out = {1'b0, 1'b0, 1'b0, sh_c};
			end
			OP_BIT: begin
				res.writes_result = 1'b0;
				res.flags_out     = {(v & bit_mask) == 8'h00, 1'b0, 1'b1, fc};
			end
			OP_RES: begin
				res.result = v & ~bit_mask;
			end
			OP_SET: begin
				res.result = v | bit_mask;
			end
			OP_DAA: begin
				res.result    = daa_val;
				res.flags_out = {daa_val == 8'h00, fn, 1'b0, daa_hi};
			end
			OP_CPL: begin
				res.result    = ~a;
				res.flags_out = {fz, 1'b1, 1'b1, fc};
			end
			OP_SCF: begin
				res.writes_result = 1'b0;
				res.flags_out     = {fz, 1'b0, 1'b0, 1'b1};
			end
			OP_CCF: begin
				res.writes_result = 1'b0;
				res.flags_out     = {fz, 1'b0, 1'b0, ~fc};
			end
			OP_ADD16: begin
				res.wide_result = w16_sum[15:0];
				res.flags_out   = {fz, 1'b0, w16_half[12], w16_sum[16]};
			end
			OP_ADDSPREL: begin
				res.wide_result = sp_sum;
				res.flags_out   = {1'b0, 1'b0, sp_half[4], sp_low[8]};
			end
			default: begin
				res.writes_result = 1'b0;
			end
		endcase
	end

endmodule
